### rtl/puw_pkg.sv
package puw_pkg;

   // field widths
   localparam int PHASE_W   = 24;
   localparam int OUT_W     = 32;
   localparam int FRAC_BITS = 13;

   // pi scaled by 2^60, rounded to fixed point with round half up
   localparam logic [63:0] PI_2P60     = 64'h3243F6A8885A308D;
   localparam logic [63:0] PI_FIX_L    =
      (PI_2P60 + (64'd1 << (59 - FRAC_BITS))) >> (60 - FRAC_BITS);
   localparam logic [63:0] TWO_PI_FIX_L =
      (PI_2P60 + (64'd1 << (58 - FRAC_BITS))) >> (59 - FRAC_BITS);

   // difference plus pi, and the floor quotient by two pi
   localparam int DIFF_W      = PHASE_W + 2;
   localparam int CONST_W     = 18;
   localparam int RECIP_SHIFT = 32;
   localparam logic [63:0] RECIP_L =
      ((64'd1 << RECIP_SHIFT) + TWO_PI_FIX_L - 64'd1) / TWO_PI_FIX_L;
   localparam int PROD_W      = DIFF_W + CONST_W;
   localparam int QUO_W       = PROD_W - RECIP_SHIFT;
   localparam int TK_W        = QUO_W + CONST_W;
   localparam int DELTA_W     = PHASE_W + 2;

   localparam logic signed [DIFF_W-1:0]  PI_D     = DIFF_W'(PI_FIX_L);
   localparam logic signed [CONST_W-1:0] RECIP_S  = CONST_W'(RECIP_L);
   localparam logic signed [CONST_W-1:0] TWO_PI_S = CONST_W'(TWO_PI_FIX_L);
   localparam logic signed [TK_W-1:0]    TWO_PI_T = TK_W'(TWO_PI_FIX_L);

   // output saturation limits
   localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
   localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

   // queue between front and back
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = 2;
   localparam int FIFO_CNT_W = 3;

   // classified item handed from front to back
   typedef struct packed {
      logic                      first;
      logic signed [PHASE_W-1:0] phase;
      logic signed [DELTA_W-1:0] delta;
   } puw_item_type;

endpackage

### rtl/phase_unwrap_stream_top.sv
// an item reaches rsp_tvalid through three front stages, queue and output register
// throughput: one item per cycle unless the queue is full; the three-stage front
// quotient pipeline and the back correction accumulate each take one item a cycle
// a four-entry queue between front and back absorbs output stalls
// reset (synchronous, active high) empties pipeline and queue and clears the
// previous sample and the running correction to zero
module phase_unwrap_stream_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [23:0] phase_in
   input  logic        req_tuser,   // [0] first_of_series
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] phase_out
   output logic        rsp_tuser    // [0] saturated
);

   logic                  push_valid;
   puw_pkg::puw_item_type push_item;
   logic                  fifo_full;
   logic                  pop;
   logic                  pop_valid;
   puw_pkg::puw_item_type pop_item;

   // difference, wrap detection and two-pi multiple
   puw_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .fifo_full  (fifo_full),
      .push_valid (push_valid),
      .push_item  (push_item)
   );

   // item queue
   puw_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .full       (fifo_full),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item)
   );

   // running correction and output
   puw_back u_back (
      .clock      (clock),
      .reset      (reset),
      .fifo_valid (pop_valid),
      .fifo_item  (pop_item),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

### rtl/puw_front.sv
module puw_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [23:0]            req_tdata,
   input  logic                   req_tuser,
   input  logic                   fifo_full,
   output logic                   push_valid,
   output puw_pkg::puw_item_type  push_item
);

   logic enable;
   logic accept;

   logic signed [puw_pkg::PHASE_W-1:0] x;
   logic signed [puw_pkg::PHASE_W-1:0] prev_ff, prev_in;
   logic signed [puw_pkg::DIFF_W-1:0]  d;
   logic signed [puw_pkg::DIFF_W-1:0]  n_in;
   logic                               wrap_in;

   logic                               s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic                               s1_first_ff, s2_first_ff, s3_first_ff;
   logic                               s1_wrap_ff, s2_wrap_ff, s3_wrap_ff;
   logic signed [puw_pkg::PHASE_W-1:0] s1_x_ff, s2_x_ff, s3_x_ff;
   logic signed [puw_pkg::DIFF_W-1:0]  s1_n_ff, s2_n_ff, s3_n_ff;

   logic signed [puw_pkg::PROD_W-1:0]  prod;
   logic signed [puw_pkg::QUO_W-1:0]   s2_q_ff, s2_q_in;
   logic signed [puw_pkg::TK_W-1:0]    s3_tk_ff, s3_tk_in;

   logic signed [puw_pkg::TK_W-1:0]    rem;
   logic signed [puw_pkg::TK_W-1:0]    tk_fix;
   logic signed [puw_pkg::TK_W-1:0]    tk_neg;

   // whole pipeline advances together, held only when the queue is full
   assign enable     = !s3_valid_ff || !fifo_full;
   assign req_tready = enable;
   assign accept     = req_tvalid && enable;

   // difference to the previous sample, plus pi for the floor division
   assign x       = signed'(req_tdata[puw_pkg::PHASE_W-1:0]);
   assign d       = puw_pkg::DIFF_W'(x) - puw_pkg::DIFF_W'(prev_ff);
   assign n_in    = d + puw_pkg::PI_D;
   assign wrap_in = (d >= puw_pkg::PI_D) || (d <= -puw_pkg::PI_D);
   assign prev_in = accept ? x : prev_ff;

   // quotient estimate by reciprocal, may be one off
   assign prod    = s1_n_ff * puw_pkg::RECIP_S;
   assign s2_q_in = prod[puw_pkg::PROD_W-1:puw_pkg::RECIP_SHIFT];

   // estimate times two pi
   assign s3_tk_in = s2_q_ff * puw_pkg::TWO_PI_S;

   // one step correction of the quotient, then negate for the delta
   always_comb begin
      rem = puw_pkg::TK_W'(s3_n_ff) - s3_tk_ff;
      if (rem < 0) begin
         tk_fix = s3_tk_ff - puw_pkg::TWO_PI_T;
      end else if (rem >= puw_pkg::TWO_PI_T) begin
         tk_fix = s3_tk_ff + puw_pkg::TWO_PI_T;
      end else begin
         tk_fix = s3_tk_ff;
      end
      tk_neg = -tk_fix;
   end

   assign push_valid      = s3_valid_ff && enable;
   assign push_item.first = s3_first_ff;
   assign push_item.phase = s3_x_ff;
   assign push_item.delta = (s3_wrap_ff && !s3_first_ff) ?
                            tk_neg[puw_pkg::DELTA_W-1:0] : '0;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff     <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         prev_ff <= prev_in;
         if (enable) begin
            s1_valid_ff <= req_tvalid;
            s2_valid_ff <= s1_valid_ff;
            s3_valid_ff <= s2_valid_ff;
         end
      end
   end

   // pipeline payload
   always_ff @(posedge clock) begin
      if (enable) begin
         s1_first_ff <= req_tuser;
         s1_wrap_ff  <= wrap_in;
         s1_x_ff     <= x;
         s1_n_ff     <= n_in;
         s2_first_ff <= s1_first_ff;
         s2_wrap_ff  <= s1_wrap_ff;
         s2_x_ff     <= s1_x_ff;
         s2_n_ff     <= s1_n_ff;
         s2_q_ff     <= s2_q_in;
         s3_first_ff <= s2_first_ff;
         s3_wrap_ff  <= s2_wrap_ff;
         s3_x_ff     <= s2_x_ff;
         s3_n_ff     <= s2_n_ff;
         s3_tk_ff    <= s3_tk_in;
      end
   end

endmodule

### rtl/puw_fifo.sv
module puw_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   input  puw_pkg::puw_item_type push_item,
   output logic                  full,
   input  logic                  pop,
   output logic                  pop_valid,
   output puw_pkg::puw_item_type pop_item
);

   puw_pkg::puw_item_type           mem_ff [puw_pkg::FIFO_DEPTH];
   logic [puw_pkg::FIFO_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [puw_pkg::FIFO_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [puw_pkg::FIFO_CNT_W-1:0]  count_ff, count_in;
   logic                            do_push;
   logic                            do_pop;

   assign full      = (count_ff == puw_pkg::FIFO_CNT_W'(puw_pkg::FIFO_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_item  = mem_ff[rd_ptr_ff];

   assign do_push = push_valid && !full;
   assign do_pop  = pop && pop_valid;

   // pointer and fill count
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

### rtl/puw_back.sv
module puw_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fifo_valid,
   input  puw_pkg::puw_item_type fifo_item,
   output logic                  pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [31:0]           rsp_tdata,
   output logic                  rsp_tuser
);

   logic signed [puw_pkg::OUT_W-1:0] corr_ff, corr_in;
   logic signed [puw_pkg::OUT_W-1:0] y_ff, y_in;
   logic                             clip_ff, clip_in;
   logic                             out_valid_ff, out_valid_in;

   logic signed [puw_pkg::OUT_W:0]   corr_sum;
   logic signed [puw_pkg::OUT_W-1:0] corr_sat;
   logic signed [puw_pkg::OUT_W:0]   y_sum;
   logic signed [puw_pkg::OUT_W-1:0] y_sat;
   logic                             corr_clip;
   logic                             y_clip;

   // take the next item when the output register is free or draining
   assign pop = fifo_valid && (!out_valid_ff || rsp_tready);

   // correction update and output sum, both saturating
   always_comb begin
      corr_sum  = (puw_pkg::OUT_W+1)'(corr_ff) + (puw_pkg::OUT_W+1)'(fifo_item.delta);
      corr_clip = corr_sum[puw_pkg::OUT_W] != corr_sum[puw_pkg::OUT_W-1];
      if (corr_clip) begin
         corr_sat = corr_sum[puw_pkg::OUT_W] ? puw_pkg::OUT_MIN : puw_pkg::OUT_MAX;
      end else begin
         corr_sat = corr_sum[puw_pkg::OUT_W-1:0];
      end
      y_sum  = (puw_pkg::OUT_W+1)'(fifo_item.phase) + (puw_pkg::OUT_W+1)'(corr_sat);
      y_clip = y_sum[puw_pkg::OUT_W] != y_sum[puw_pkg::OUT_W-1];
      if (y_clip) begin
         y_sat = y_sum[puw_pkg::OUT_W] ? puw_pkg::OUT_MIN : puw_pkg::OUT_MAX;
      end else begin
         y_sat = y_sum[puw_pkg::OUT_W-1:0];
      end
   end

   // first sample of a series passes through and clears the correction
   always_comb begin
      corr_in      = corr_ff;
      y_in         = y_ff;
      clip_in      = clip_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      if (pop) begin
         out_valid_in = 1'b1;
         if (fifo_item.first) begin
            corr_in = '0;
            y_in    = puw_pkg::OUT_W'(fifo_item.phase);
            clip_in = 1'b0;
         end else begin
            corr_in = corr_sat;
            y_in    = y_sat;
            clip_in = corr_clip || y_clip;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         corr_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         corr_ff      <= corr_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      y_ff    <= y_in;
      clip_ff <= clip_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = y_ff;
   assign rsp_tuser  = clip_ff;

endmodule

### dv/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PHASE_W = puw_pkg::PHASE_W;
   localparam int OUT_W   = puw_pkg::OUT_W;

   // fixed point pi and two pi at 13 fraction bits, and the output range
   localparam int     PI_Q      = 25736;
   localparam int     TWO_PI_Q  = 51472;
   localparam longint OUT_HI    = 64'sd2147483647;
   localparam longint OUT_LO    = -OUT_HI - 1;
   localparam int     IDLE_MAX  = 2000;
   localparam int     RAND_ITEMS = 1280;
   localparam int     RAMP_PAIRS = 150;

   typedef struct packed {
      logic [OUT_W-1:0] phase;
      logic             sat;
   } unwrapped_type;

   typedef struct packed {
      logic [PHASE_W-1:0] phase;
      logic               first;
      logic               typed;
      logic [OUT_W-1:0]   y;
      logic               sat;
   } stim_row_type;

   // directed items; typed rows carry the result read straight off the spec
   localparam stim_row_type DIRECTED_ROWS [19] = '{
      '{24'd0,               1'b0, 1'b1, 32'd0,              1'b0},  // no first since reset
      '{24'(25736),          1'b0, 1'b1, 32'(-25736),        1'b0},  // step of exactly pi
      '{24'd0,               1'b0, 1'b1, 32'(-51472),        1'b0},  // step of exactly minus pi
      '{24'h7FFFFF,          1'b1, 1'b1, 32'(8388607),       1'b0},  // first, max sample
      '{24'h800000,          1'b0, 1'b0, 32'd0,              1'b0},
      '{24'h7FFFFF,          1'b0, 1'b0, 32'd0,              1'b0},
      '{24'h800000,          1'b1, 1'b1, 32'(-8388608),      1'b0},  // first, min sample
      '{24'h7FFFFF,          1'b0, 1'b0, 32'd0,              1'b0},
      '{24'd0,               1'b1, 1'b1, 32'd0,              1'b0},
      '{24'(25735),          1'b0, 1'b1, 32'(25735),         1'b0},  // just under pi
      '{24'hFFFFFE,          1'b0, 1'b0, 32'd0,              1'b0},  // just beyond minus pi
      '{24'hFFFFFF,          1'b0, 1'b0, 32'd0,              1'b0},
      '{24'h555555,          1'b0, 1'b0, 32'd0,              1'b0},
      '{24'hAAAAAA,          1'b0, 1'b0, 32'd0,              1'b0},
      '{24'h800000,          1'b0, 1'b0, 32'd0,              1'b0},
      '{24'd1,               1'b1, 1'b1, 32'd1,              1'b0},
      '{24'(-25735),         1'b0, 1'b1, 32'(-25735),        1'b0},  // minus pi again
      '{24'(25737),          1'b0, 1'b0, 32'd0,              1'b0},  // exactly two pi
      '{24'h800000,          1'b0, 1'b0, 32'd0,              1'b0}
   };

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_tvalid;
   logic               req_tready;
   logic [PHASE_W-1:0] req_tdata;
   logic               req_tuser;
   logic               rsp_tvalid;
   logic               rsp_tready;
   logic [OUT_W-1:0]   rsp_tdata;
   logic               rsp_tuser;

   // predictor state
   logic signed [PHASE_W-1:0] last_phase;
   logic signed [OUT_W-1:0]   phase_correction;

   unwrapped_type pending_unwraps[$];
   int            err_count   = 0;
   int            idle_cycles = 0;
   bit            steady_flow = 1'b0;

   phase_unwrap_stream_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // clamp to the signed output range, noting any clipping
   function automatic logic signed [OUT_W-1:0] clip_to_out(input longint v, inout bit clip);
      if (v > OUT_HI) begin
         clip = 1'b1;
         return OUT_W'(OUT_HI);
      end
      if (v < OUT_LO) begin
         clip = 1'b1;
         return OUT_W'(OUT_LO);
      end
      return OUT_W'(v);
   endfunction

   // unwrap one sample against the stored previous sample and correction
   function automatic unwrapped_type unwrap_predict(input logic [PHASE_W-1:0] ph,
                                                    input logic fs);
      longint        x;
      longint        d;
      longint        num;
      longint        k;
      bit            clip;
      unwrapped_type r;
      x    = longint'($signed(ph));
      clip = 1'b0;
      if (fs) begin
         phase_correction = '0;
         r.phase = clip_to_out(x, clip);
      end else begin
         d = x - longint'(last_phase);
         if (d >= PI_Q || -d >= PI_Q) begin
            // floor division toward minus infinity
            num = d + PI_Q;
            k   = num / TWO_PI_Q;
            if (num % TWO_PI_Q != 0 && num < 0)
               k = k - 1;
            phase_correction = clip_to_out(longint'(phase_correction) - TWO_PI_Q * k, clip);
         end
         r.phase = clip_to_out(x + longint'(phase_correction), clip);
      end
      last_phase = ph;
      r.sat = clip;
      return r;
   endfunction

   function automatic int pick_gap();
      int r;
      if (steady_flow)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 93)
         return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic void flag_error(input string msg);
      if (err_count < 10)
         $display("mismatch at %0t ns: %s", $time, msg);
      err_count++;
   endfunction

   // offer one item, wait for the handshake, then record what it should produce
   task automatic send_sample(input logic [PHASE_W-1:0] ph, input logic fs,
                              input logic typed, input unwrapped_type typed_res);
      int            gap;
      unwrapped_type predicted;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= ph;
      req_tuser  <= fs;
      do @(posedge clock); while (req_tready !== 1'b1);
      predicted = unwrap_predict(ph, fs);
      pending_unwraps.push_back(typed ? typed_res : predicted);
   endtask

   // hold off the sender until every result is back
   task automatic await_drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_unwraps.size() != 0) @(posedge clock);
   endtask

   // receiver stalls: mostly short, sometimes long, none in steady flow
   initial begin : drive_ready
      int r;
      int run;
      bit go;
      rsp_tready = 1'b0;
      wait (reset == 1'b0);
      forever begin
         if (steady_flow) begin
            go  = 1'b1;
            run = 1;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 65) begin
               go  = 1'b1;
               run = $urandom_range(1, 12);
            end else if (r < 93) begin
               go  = 1'b0;
               run = $urandom_range(1, 3);
            end else begin
               go  = 1'b0;
               run = $urandom_range(15, 60);
            end
         end
         repeat (run) begin
            @(negedge clock);
            rsp_tready <= go;
         end
      end
   end

   // compare each accepted result with the oldest expectation
   always @(posedge clock) begin : check_results
      unwrapped_type want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         if (pending_unwraps.size() == 0) begin
            flag_error($sformatf("unexpected item phase_out=%0d saturated=%0b",
                                 $signed(rsp_tdata), rsp_tuser));
         end else begin
            want = pending_unwraps.pop_front();
            if (rsp_tdata !== want.phase)
               flag_error($sformatf("phase_out expected %0d got %0d",
                                    $signed(want.phase), $signed(rsp_tdata)));
            if (rsp_tuser !== want.sat)
               flag_error($sformatf("saturated expected %0b got %0b", want.sat, rsp_tuser));
         end
      end
   end

   // watchdog on cycles with no item moving on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_MAX) begin
         $display("testbench: FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      longint             cur;
      longint             step;
      logic [PHASE_W-1:0] ph;
      logic               fs;
      int                 series_left;
      int                 r;
      unwrapped_type      typed_res;
      req_tvalid       = 1'b0;
      req_tdata        = '0;
      req_tuser        = 1'b0;
      last_phase       = '0;
      phase_correction = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed items
      foreach (DIRECTED_ROWS[i]) begin
         typed_res.phase = DIRECTED_ROWS[i].y;
         typed_res.sat   = DIRECTED_ROWS[i].sat;
         send_sample(DIRECTED_ROWS[i].phase, DIRECTED_ROWS[i].first,
                     DIRECTED_ROWS[i].typed, typed_res);
      end
      await_drain();

      // ramps that keep pushing the correction one way, then the other;
      // every down step just past minus pi adds two pi, and the reverse
      steady_flow = 1'b1;
      cur = 100000;
      send_sample(PHASE_W'(cur), 1'b1, 1'b0, '0);
      for (int j = 0; j < RAMP_PAIRS; j++) begin
         cur = cur + (PI_Q - 1);
         send_sample(PHASE_W'(cur), 1'b0, 1'b0, '0);
         cur = cur - (PI_Q + 1);
         send_sample(PHASE_W'(cur), 1'b0, 1'b0, '0);
      end
      cur = -100000;
      send_sample(PHASE_W'(cur), 1'b1, 1'b0, '0);
      for (int j = 0; j < RAMP_PAIRS; j++) begin
         cur = cur - (PI_Q - 1);
         send_sample(PHASE_W'(cur), 1'b0, 1'b0, '0);
         cur = cur + (PI_Q + 1);
         send_sample(PHASE_W'(cur), 1'b0, 1'b0, '0);
      end
      steady_flow = 1'b0;
      await_drain();

      // random series of wrapped phase with stray first flags and wild samples
      series_left = 0;
      cur = 0;
      for (int i = 0; i < RAND_ITEMS; i++) begin
         fs = (series_left == 0) || ($urandom_range(0, 99) == 0);
         if (series_left == 0)
            series_left = $urandom_range(20, 150);
         series_left--;
         r = $urandom_range(0, 99);
         if (r < 40) begin
            step = longint'($urandom_range(0, 2 * PI_Q - 2)) - (PI_Q - 1);
            ph   = PHASE_W'(cur + step);
         end else if (r < 60) begin
            step = PI_Q + longint'($urandom_range(0, 6)) - 3;
            ph   = PHASE_W'($urandom_range(0, 1) ? cur + step : cur - step);
         end else if (r < 75) begin
            step = longint'($urandom_range(0, 8 * TWO_PI_Q)) - 4 * TWO_PI_Q;
            ph   = PHASE_W'(cur + step);
         end else if (r < 92) begin
            ph = PHASE_W'($urandom());
         end else begin
            case ($urandom_range(0, 2))
               0: ph = 24'h7FFFFF;
               1: ph = 24'h800000;
               default: ph = 24'h000000;
            endcase
         end
         cur = longint'($signed(ph));
         steady_flow = ($urandom_range(0, 99) < 5) ? ~steady_flow : steady_flow;
         send_sample(ph, fs, 1'b0, '0);
      end
      steady_flow = 1'b0;

      // wait for the last results, then keep the clock running to catch strays
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_unwraps.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (err_count == 0 && pending_unwraps.size() == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule

### phase_unwrap_stream_top.f
rtl/puw_pkg.sv
rtl/puw_front.sv
rtl/puw_fifo.sv
rtl/puw_back.sv
rtl/phase_unwrap_stream_top.sv
dv/testbench.sv
